FILE: hdl/brf_pkg.sv
package brf_pkg;

  // Store geometry: DEPTH slots, one always kept free.
  localparam int unsigned DEPTH = 8192;
  localparam int unsigned PTR_W = $clog2(DEPTH);

  // Item field widths.
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned LEN_W    = 13;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned FILL_W   = 13;

  // Packet size register.
  localparam int unsigned PSIZE_W = 7;
  localparam logic [PSIZE_W-1:0] PSIZE_RESET = 7'd30;
  localparam logic [PSIZE_W-1:0] MAX_PACKET  = 7'd64;

  // Configuration port.
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic REG_PACKET_SIZE = 1'b0;

  // Width that holds every quantity compared against the fill level.
  localparam int unsigned CMP_W = ((PTR_W > LEN_W) ? PTR_W : LEN_W) + 1;

  typedef logic [PTR_W-1:0] ptr_t;

  localparam ptr_t PTR_LAST = ptr_t'(DEPTH - 1);
  localparam logic [PTR_W:0] DEPTH_EXT = (PTR_W + 1)'(DEPTH);

  typedef enum logic [CMD_W-1:0] {
    CMD_BURST = 2'd0,
    CMD_BYTE  = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_BURST_OK     = 3'd0,
    ST_BURST_REJECT = 3'd1,
    ST_BYTE_DONE    = 3'd2,
    ST_READ_BYTE    = 3'd3,
    ST_READ_REFUSED = 3'd4
  } status_t;

  // Next slot round the ring.
  function automatic ptr_t ptr_inc(input ptr_t p);
    return (p == PTR_LAST) ? '0 : ptr_t'(p + 1'b1);
  endfunction

  // Bytes stored between the read and write pointers.
  function automatic ptr_t fill_of(input ptr_t tail, input ptr_t head);
    logic [PTR_W:0] diff;
    diff = {1'b0, tail} + ((tail < head) ? DEPTH_EXT : '0) - {1'b0, head};
    return diff[PTR_W-1:0];
  endfunction

  // Fill level as carried in a result item (low bits only).
  function automatic logic [FILL_W-1:0] fill_field(input ptr_t fill);
    logic [PTR_W+FILL_W-1:0] wide;
    wide = {{FILL_W{1'b0}}, fill};
    return wide[FILL_W-1:0];
  endfunction

endpackage

FILE: hdl/brf_if.sv
// Request channel: one command item per handshake.
interface brf_req_if;
  logic                          valid;
  logic                          ready;
  logic [brf_pkg::CMD_W-1:0]     command;
  logic [brf_pkg::LEN_W-1:0]     burst_length;
  logic [brf_pkg::BYTE_W-1:0]    data_byte;

  modport source (output valid, command, burst_length, data_byte, input ready);
  modport sink (input valid, command, burst_length, data_byte, output ready);
endinterface

// Response channel: one result item per handshake.
interface brf_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [brf_pkg::STATUS_W-1:0]  status;
  logic [brf_pkg::BYTE_W-1:0]    data_out;
  logic                          last;
  logic [brf_pkg::FILL_W-1:0]    fill_level;

  modport source (output valid, status, data_out, last, fill_level, input ready);
  modport sink (input valid, status, data_out, last, fill_level, output ready);
endinterface

FILE: hdl/byte_ring_fifo_bulk_transfer_top.sv
// Channel  Role      Payload
// req      sink      command, burst_length, data_byte
// rsp      source    status, data_out, last, fill_level
// apb      slave     packet_size at byte address 0
//
// Burst announcements, byte writes and refused reads each give one result item
// from the output register.
// A granted read gives packet_size result items (at most 64), one per cycle through
// the single read port of the store while the result channel is not stalled.
// Reset is synchronous; the store itself is not cleared, only pointers and control state.
// A stalled result holds the next item back; a stalled read packet pauses.
module byte_ring_fifo_bulk_transfer_top (
  input  logic                            clk,
  input  logic                            rst,
  brf_req_if.sink                         req,
  brf_rsp_if.source                       rsp,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [brf_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [brf_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [brf_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);

  logic [brf_pkg::PSIZE_W-1:0]  packet_size;
  logic                         ram_we;
  brf_pkg::ptr_t                ram_waddr;
  logic [brf_pkg::BYTE_W-1:0]   ram_wdata;
  logic                         ram_re;
  brf_pkg::ptr_t                ram_raddr;
  logic [brf_pkg::BYTE_W-1:0]   ram_rdata;

  // Configuration register.
  brf_apb u_apb (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .packet_size (packet_size)
  );

  // Byte store.
  brf_ram #(
    .WIDTH (brf_pkg::BYTE_W),
    .DEPTH (brf_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Ring control.
  brf_core u_core (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .rsp         (rsp),
    .packet_size (packet_size),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata)
  );

endmodule

FILE: hdl/brf_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
module brf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/brf_apb.sv
// Configuration register file: the packet size register.
module brf_apb (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [brf_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [brf_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [brf_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready,
  output logic [brf_pkg::PSIZE_W-1:0]        packet_size
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == brf_pkg::REG_PACKET_SIZE);

  // Write takes effect in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      packet_size <= brf_pkg::PSIZE_RESET;
    end else if (wr_en) begin
      packet_size <= pwdata[brf_pkg::PSIZE_W-1:0];
    end
  end

  // Read back; addresses beyond the register read as zero.
  always_comb begin
    prdata = '0;
    if (paddr[2] == brf_pkg::REG_PACKET_SIZE) begin
      prdata[brf_pkg::PSIZE_W-1:0] = packet_size;
    end
  end

endmodule

FILE: hdl/brf_core.sv
// Ring control: pointers, burst bookkeeping, packet read sequencer and
// the result register. Byte storage lives in the RAM outside.
module brf_core (
  input  logic                            clk,
  input  logic                            rst,
  brf_req_if.sink                         req,
  brf_rsp_if.source                       rsp,
  input  logic [brf_pkg::PSIZE_W-1:0]     packet_size,
  output logic                            ram_we,
  output brf_pkg::ptr_t                   ram_waddr,
  output logic [brf_pkg::BYTE_W-1:0]      ram_wdata,
  output logic                            ram_re,
  output brf_pkg::ptr_t                   ram_raddr,
  input  logic [brf_pkg::BYTE_W-1:0]      ram_rdata
);

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  state_t                         state;
  brf_pkg::ptr_t                  head;
  brf_pkg::ptr_t                  tail;
  logic [brf_pkg::LEN_W-1:0]      burst_rem;
  logic [brf_pkg::PSIZE_W-1:0]    rd_left;
  logic                           rd_pend;
  logic                           pend_last;
  brf_pkg::ptr_t                  pend_fill;

  logic                           out_valid;
  logic [brf_pkg::STATUS_W-1:0]   out_status;
  logic [brf_pkg::BYTE_W-1:0]     out_data;
  logic                           out_last;
  logic [brf_pkg::FILL_W-1:0]     out_fill;

  logic                           out_free;
  logic                           out_load;
  logic                           accept;
  brf_pkg::ptr_t                  fill_now;
  brf_pkg::ptr_t                  head_inc;
  brf_pkg::ptr_t                  tail_inc;
  brf_pkg::ptr_t                  avail;
  logic                           len_ok;
  logic [brf_pkg::PSIZE_W-1:0]    pkt_n;
  logic                           refuse;
  logic                           byte_room;
  brf_pkg::ptr_t                  byte_fill;
  logic                           rd_issue;
  logic                           rd_load;

  // Handshake: the result register frees when its item is taken.
  assign out_free  = !out_valid || rsp.ready;
  assign req.ready = (state == S_IDLE) && out_free;
  assign accept    = req.valid && req.ready;

  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.data_out   = out_data;
  assign rsp.last       = out_last;
  assign rsp.fill_level = out_fill;

  // Ring arithmetic.
  assign fill_now = brf_pkg::fill_of(tail, head);
  assign head_inc = brf_pkg::ptr_inc(head);
  assign tail_inc = brf_pkg::ptr_inc(tail);

  // A burst is taken only if the free space covers its whole length.
  assign avail  = brf_pkg::PTR_LAST - fill_now;
  assign len_ok = brf_pkg::CMP_W'(req.burst_length) <= brf_pkg::CMP_W'(avail);

  // Packet length, clipped to the largest packet.
  assign pkt_n  = (packet_size > brf_pkg::MAX_PACKET) ? brf_pkg::MAX_PACKET : packet_size;
  assign refuse = (pkt_n == '0) || (brf_pkg::CMP_W'(fill_now) < brf_pkg::CMP_W'(pkt_n));

  // Byte write goes to the store only inside an open burst with room.
  assign byte_room = tail_inc != head;
  assign ram_we    = accept && (req.command == brf_pkg::CMD_BYTE) &&
                     (burst_rem != '0) && byte_room;
  assign ram_waddr = tail;
  assign ram_wdata = req.data_byte;
  assign byte_fill = brf_pkg::fill_of(ram_we ? tail_inc : tail, head);

  // Packet reads: one RAM read per cycle; the read data register acts as a
  // holding stage, so a new read is issued only when it can be emptied.
  assign rd_load   = (state == S_READ) && rd_pend && out_free;
  assign rd_issue  = (state == S_READ) && (rd_left != '0) && (!rd_pend || out_free);
  assign ram_re    = rd_issue;
  assign ram_raddr = head;

  // The result register takes a new item on every answered command and on
  // every byte of a packet.
  assign out_load = (accept && ((req.command == brf_pkg::CMD_BURST) ||
                                (req.command == brf_pkg::CMD_BYTE) ||
                                ((req.command == brf_pkg::CMD_READ) && refuse))) ||
                    rd_load;

  // State, pointers and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      burst_rem <= '0;
      rd_left   <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (req.command)
              brf_pkg::CMD_BURST: begin
                burst_rem  <= len_ok ? req.burst_length : '0;
                out_status <= len_ok ? brf_pkg::ST_BURST_OK : brf_pkg::ST_BURST_REJECT;
                out_data   <= '0;
                out_last   <= 1'b1;
                out_fill   <= brf_pkg::fill_field(fill_now);
              end
              brf_pkg::CMD_BYTE: begin
                if (burst_rem != '0) begin
                  burst_rem <= burst_rem - 1'b1;
                end
                if (ram_we) begin
                  tail <= tail_inc;
                end
                out_status <= brf_pkg::ST_BYTE_DONE;
                out_data   <= '0;
                out_last   <= 1'b1;
                out_fill   <= brf_pkg::fill_field(byte_fill);
              end
              brf_pkg::CMD_READ: begin
                if (refuse) begin
                  out_status <= brf_pkg::ST_READ_REFUSED;
                  out_data   <= '0;
                  out_last   <= 1'b1;
                  out_fill   <= brf_pkg::fill_field(fill_now);
                end else begin
                  state   <= S_READ;
                  rd_left <= pkt_n;
                end
              end
              default: begin
                // Unused command code: taken and dropped without a result.
              end
            endcase
          end
        end
        S_READ: begin
          if (rd_issue) begin
            head      <= head_inc;
            rd_left   <= rd_left - 1'b1;
            rd_pend   <= 1'b1;
            pend_last <= (rd_left == 7'd1);
            pend_fill <= brf_pkg::fill_of(tail, head_inc);
          end
          if (rd_load) begin
            out_status <= brf_pkg::ST_READ_BYTE;
            out_data   <= ram_rdata;
            out_last   <= pend_last;
            out_fill   <= brf_pkg::fill_field(pend_fill);
            if (!rd_issue) begin
              rd_pend <= 1'b0;
            end
            if (pend_last) begin
              state <= S_IDLE;
            end
          end
        end
      endcase
    end
  end

endmodule

FILE: hdl/brf_checker.sv
// Port-level checks on the result channel.
module brf_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            req_ready,
  input logic                            rsp_valid,
  input logic                            rsp_ready,
  input logic [brf_pkg::STATUS_W-1:0]    status,
  input logic [brf_pkg::BYTE_W-1:0]      data_out,
  input logic                            last,
  input logic [brf_pkg::FILL_W-1:0]      fill_level
);

  // Reset empties the result register.
  a_reset_clears: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  // A stalled result item holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(data_out) &&
                                $stable(last) && $stable(fill_level))
    else $error("stalled result changed");

  // Only read bytes carry data, and every other result closes its item.
  a_single: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status != brf_pkg::ST_READ_BYTE) |-> last && (data_out == '0))
    else $error("non-read result with data or without last");

  // No new item is taken in the middle of a packet.
  a_packet_blocks: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == brf_pkg::ST_READ_BYTE) && !last |-> !req_ready)
    else $error("item taken inside a packet");

endmodule

bind byte_ring_fifo_bulk_transfer_top brf_checker u_chk (
  .clk        (clk),
  .rst        (rst),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .status     (rsp.status),
  .data_out   (rsp.data_out),
  .last       (rsp.last),
  .fill_level (rsp.fill_level)
);
